// ===== hdl/sorted_table_binary_search_macros.svh =====
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define STBS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds whenever its antecedent holds.
`define STBS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/stbs_pkg.sv =====
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W = 11;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } stbs_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } stbs_rd_t;

endpackage

// ===== hdl/stbs_table.sv =====
module stbs_table (
  input  logic                       clk,
  input  stbs_pkg::stbs_wr_t         wr,
  input  stbs_pkg::stbs_rd_t         rd,
  output logic [stbs_pkg::DATA_W-1:0] rd_data
);
  import stbs_pkg::*;

  logic [DATA_W-1:0] mem [TABLE_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/sorted_table_binary_search.sv =====
// Table of signed 32-bit elements, appended in ascending order, with binary search.
// A request is taken at a rising edge where start is high and busy is low. It
// carries in_opcode (clear, append or search), in_element_value for an append
// and in_search_key for a search. Every request gives exactly one result on
// out_status and out_position, marked by out_strobe for a single cycle.
// Clear, append and unused opcodes answer in the cycle after the request and
// leave busy low, so such requests may follow each other in every cycle.
// A search holds busy high while it probes the table. Each probe first reads
// the table memory at the middle of the interval (S_PROBE) and then compares
// the registered word with the key (S_CMP). A search ends when the key is
// found or the interval is empty; the table holds at most 1024 elements, and
// an empty table answers without any read. The single table read port and
// the compare behind it keep the probes of a search in sequence.
// Reset clears the element count and the control state; the table memory is
// not cleared, since only entries below the count are ever read.
// The receiver cannot stall: a result is valid only in its strobe cycle.
module sorted_table_binary_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_opcode,
  input  logic signed [stbs_pkg::DATA_W-1:0] in_element_value,
  input  logic signed [stbs_pkg::DATA_W-1:0] in_search_key,
  output logic                               out_strobe,
  output logic [1:0]                         out_status,
  output logic [stbs_pkg::POS_W-1:0]         out_position
);
  import stbs_pkg::*;
  `include "sorted_table_binary_search_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hend_r, hend_nxt;
  logic [CNT_W-1:0]         mid_r, mid_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     strobe_r, strobe_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [POS_W-1:0]         position_r, position_nxt;
  logic [CNT_W-1:0]         mid_calc;
  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W-1:0] elem;
  stbs_wr_t                 wr;
  stbs_rd_t                 rd;

  stbs_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign mid_calc = lo_r + ((hend_r - lo_r - CNT_W'(1)) >> 1);
  assign elem = $signed(rd_data);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt = lo_r;
    hend_nxt = hend_r;
    mid_nxt = mid_r;
    key_nxt = key_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    position_nxt = position_r;
    wr.en = 1'b0;
    wr.addr = count_r[ADDR_W-1:0];
    wr.data = in_element_value;
    rd.en = 1'b0;
    rd.addr = mid_calc[ADDR_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt = ST_ACCEPTED;
          position_nxt = '0;
          unique case (in_opcode)
            OP_CLEAR: begin
              count_nxt = '0;
              strobe_nxt = 1'b1;
            end
            OP_APPEND: begin
              strobe_nxt = 1'b1;
              if (count_r < CNT_W'(TABLE_DEPTH)) begin
                wr.en = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                status_nxt = ST_FULL;
              end
            end
            OP_SEARCH: begin
              lo_nxt = '0;
              hend_nxt = count_r;
              key_nxt = in_search_key;
              state_nxt = S_PROBE;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_PROBE: begin
        if (lo_r >= hend_r) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_NOT_FOUND;
          position_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          rd.en = 1'b1;
          mid_nxt = mid_calc;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (elem == key_r) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_FOUND;
          position_nxt = POS_W'(mid_r + CNT_W'(1));
          state_nxt = S_IDLE;
        end else begin
          if (elem < key_r) begin
            lo_nxt = mid_r + CNT_W'(1);
          end else begin
            hend_nxt = mid_r;
          end
          state_nxt = S_PROBE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      strobe_r <= strobe_nxt;
    end
    lo_r <= lo_nxt;
    hend_r <= hend_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    status_r <= status_nxt;
    position_r <= position_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_position = position_r;

  `STBS_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(TABLE_DEPTH), "element count above table depth")
  `STBS_ASSERT_IMPL(a_probe_in_table, state_r == S_CMP, mid_r < count_r, "probe outside the filled table")
  `STBS_ASSERT_IMPL(a_found_position, out_strobe && out_status == ST_FOUND, out_position != '0, "found result without a position")
  `STBS_ASSERT_IMPL(a_strobe_cause, out_strobe, $past(start && !busy) || $past(busy), "result without a request")

endmodule

// ===== test/sorted_table_binary_search_tb.sv =====
module sorted_table_binary_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
  } table_response_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_opcode = OP_CLEAR;
  logic signed [DATA_W-1:0] in_element_value = '0;
  logic signed [DATA_W-1:0] in_search_key = '0;
  logic                     out_strobe;
  logic [1:0]               out_status;
  logic [POS_W-1:0]         out_position;

  logic signed [DATA_W-1:0] model_table [TABLE_DEPTH];
  int                       model_count = 0;
  table_response_t          pending_responses[$];
  table_response_t          oldest_response;
  int                       requests_sent = 0;
  int                       idle_pct = 0;
  int                       error_count = 0;
  int                       cycle_count = 0;

  sorted_table_binary_search i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_element_value (in_element_value),
    .in_search_key    (in_search_key),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_position     (out_position)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Updates the table copy and returns the response the block must give.
  function automatic table_response_t predict_table_response(
    input logic [1:0]               op,
    input logic signed [DATA_W-1:0] val,
    input logic signed [DATA_W-1:0] key
  );
    table_response_t r;
    int lo;
    int hi;
    int mid;
    r.status = ST_ACCEPTED;
    r.position = '0;
    if (op == OP_CLEAR) begin
      model_count = 0;
    end else if (op == OP_APPEND) begin
      if (model_count < TABLE_DEPTH) begin
        model_table[model_count] = val;
        model_count++;
      end else begin
        r.status = ST_FULL;
      end
    end else if (op == OP_SEARCH) begin
      lo = 0;
      hi = model_count - 1;
      r.status = ST_NOT_FOUND;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (model_table[mid] == key) begin
          r.status = ST_FOUND;
          r.position = POS_W'(mid + 1);
          break;
        end
        if (model_table[mid] < key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_responses.size() == 0) begin
        $error("response with no request outstanding: status %0d, position %0d",
               out_status, out_position);
        error_count++;
      end else begin
        oldest_response = pending_responses.pop_front();
        if (out_status !== oldest_response.status) begin
          $error("out_status mismatch: expected %0d, actual %0d",
                 oldest_response.status, out_status);
          error_count++;
        end
        if (out_position !== oldest_response.position) begin
          $error("out_position mismatch: expected %0d, actual %0d",
                 oldest_response.position, out_position);
          error_count++;
        end
      end
    end
  end

  task automatic send_request(
    input logic [1:0]               op,
    input logic signed [DATA_W-1:0] val,
    input logic signed [DATA_W-1:0] key
  );
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_element_value <= val;
    in_search_key <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_responses.push_back(predict_table_response(op, val, key));
    requests_sent++;
  endtask

  task automatic wait_for_responses();
    start <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  task automatic load_sorted_table(input int n, input bit narrow);
    longint cur;
    send_request(OP_CLEAR, $urandom(), $urandom());
    if (narrow) begin
      cur = longint'($urandom_range(0, 60)) - 30;
    end else begin
      cur = -64'sd2147483648 + longint'($urandom_range(0, 100000));
    end
    for (int i = 0; i < n; i++) begin
      send_request(OP_APPEND, cur[DATA_W-1:0], $urandom());
      if (narrow) begin
        cur = cur + longint'($urandom_range(0, 3));
      end else begin
        cur = cur + longint'($urandom_range(1, 32'd4000000000 / (n + 1)));
      end
      if (cur > 2147483647) begin
        cur = 2147483647;
      end
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_search_key();
    int sel;
    int idx;
    sel = $urandom_range(0, 9);
    if (sel == 9) begin
      return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    if (model_count == 0 || sel == 8) begin
      return $urandom();
    end
    idx = $urandom_range(0, model_count - 1);
    case (sel)
      6: return model_table[idx] + 1;
      7: return model_table[idx] - 1;
      default: return model_table[idx];
    endcase
  endfunction

  task automatic directed_extremes_test();
    send_request(OP_SEARCH, $urandom(), $urandom());
    send_request(OP_UNUSED, $urandom(), $urandom());
    send_request(OP_CLEAR, $urandom(), $urandom());
    send_request(OP_APPEND, 32'sh8000_0000, $urandom());
    send_request(OP_APPEND, -32'sd1, $urandom());
    send_request(OP_APPEND, 32'sd0, $urandom());
    send_request(OP_APPEND, 32'sd1, $urandom());
    send_request(OP_APPEND, 32'sh7fff_ffff, $urandom());
    send_request(OP_SEARCH, $urandom(), 32'sh8000_0000);
    send_request(OP_SEARCH, $urandom(), 32'sh7fff_ffff);
    send_request(OP_SEARCH, $urandom(), 32'sd0);
    send_request(OP_SEARCH, $urandom(), -32'sd1);
    send_request(OP_SEARCH, $urandom(), 32'sd1);
    send_request(OP_SEARCH, $urandom(), 32'sd2);
    send_request(OP_UNUSED, $urandom(), $urandom());
    send_request(OP_CLEAR, $urandom(), $urandom());
    send_request(OP_SEARCH, $urandom(), 32'sd0);
    wait_for_responses();
  endtask

  task automatic unsorted_duplicates_test();
    repeat (3) send_request(OP_APPEND, 32'sd7, $urandom());
    send_request(OP_SEARCH, $urandom(), 32'sd7);
    send_request(OP_CLEAR, $urandom(), $urandom());
    send_request(OP_APPEND, 32'sd9, $urandom());
    send_request(OP_APPEND, 32'sd1, $urandom());
    send_request(OP_APPEND, 32'sd5, $urandom());
    send_request(OP_APPEND, 32'sd3, $urandom());
    send_request(OP_SEARCH, $urandom(), 32'sd3);
    send_request(OP_SEARCH, $urandom(), 32'sd1);
    wait_for_responses();
  endtask

  task automatic random_table_test(input int item_goal);
    int first;
    int n;
    int searches;
    first = requests_sent;
    while (requests_sent - first < item_goal) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
      load_sorted_table(n, 1'($urandom_range(0, 1)));
      searches = $urandom_range(2, 8);
      for (int i = 0; i < searches; i++) begin
        case ($urandom_range(0, 11))
          0: send_request(OP_UNUSED, $urandom(), $urandom());
          1: send_request(OP_APPEND, $urandom(), $urandom());
          default: send_request(OP_SEARCH, $urandom(), pick_search_key());
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        wait_for_responses();
      end
    end
    wait_for_responses();
  endtask

  task automatic full_table_test();
    load_sorted_table(TABLE_DEPTH, 1'b0);
    repeat (3) send_request(OP_APPEND, $urandom(), $urandom());
    send_request(OP_SEARCH, $urandom(), model_table[0]);
    send_request(OP_SEARCH, $urandom(), model_table[TABLE_DEPTH-1]);
    repeat (40) send_request(OP_SEARCH, $urandom(), pick_search_key());
    send_request(OP_UNUSED, $urandom(), $urandom());
    send_request(OP_CLEAR, $urandom(), $urandom());
    send_request(OP_SEARCH, $urandom(), model_table[0]);
    wait_for_responses();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 35;
    directed_extremes_test();
    unsorted_duplicates_test();
    random_table_test(130);
    idle_pct = 65;
    random_table_test(130);
    idle_pct = 0;
    random_table_test(130);
    full_table_test();
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
